// ===== rtl/core/spmd_pkg.sv =====
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared widths, limits and types for the network delay block.
// ----------------------------------------------------------------------------
package spmd_pkg;
  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_W      = 7;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int EADDR_W     = $clog2(MAX_EDGES);
  localparam int ECNT_W      = $clog2(MAX_EDGES + 1);
  localparam int DIST_W      = 23;
  localparam int EDGE_W      = 2 * NODE_W + WEIGHT_BITS;
  localparam logic [DIST_W-1:0] DELAY_MASK = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DELAY_MAX  = {1'b0, {(DIST_W-1){1'b1}}};

  typedef struct packed {
    logic [NODE_W-1:0]      from;
    logic [NODE_W-1:0]      to;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  // Distance memory access issued by the controller.
  typedef struct packed {
    logic              rd;
    logic [IDX_W-1:0]  raddr;
    logic              wr;
    logic [IDX_W-1:0]  waddr;
    logic [DIST_W-1:0] wdata;
  } dist_req_t;
endpackage

// ===== rtl/core/spmd_edge_ram.sv =====
// ----------------------------------------------------------------------------
// spmd_edge_ram
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spmd_edge_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [spmd_pkg::EADDR_W-1:0] waddr,
  input  spmd_pkg::edge_t              wdata,
  input  logic [spmd_pkg::EADDR_W-1:0] raddr,
  output spmd_pkg::edge_t              rdata
);
  spmd_pkg::edge_t mem [spmd_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/spmd_dist_ram.sv =====
// ----------------------------------------------------------------------------
// spmd_dist_ram
// Node distance store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spmd_dist_ram (
  input  logic                        clk,
  input  spmd_pkg::dist_req_t         req,
  output logic [spmd_pkg::DIST_W-1:0] rdata
);
  logic [spmd_pkg::DIST_W-1:0] mem [spmd_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== rtl/core/shortest_path_max_delay.sv =====
// ----------------------------------------------------------------------------
// shortest_path_max_delay
// Loads directed edges, then runs single-source shortest paths and reports
// the largest distance, or -1 when some node is unreachable.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  edge in   in_valid/in_ready  edge_from edge_to edge_weight last_edge
//  result    out_valid/out_ready network_delay
//  config    cfg_we             cfg_index cfg_data
//
// Edges are taken one per cycle while loading. After the last edge the block
// runs up to n settle rounds; each round scans the n nodes and then streams
// all stored edges through the distance memory. One more scan that finds no
// node and a final scan that forms the maximum close the run. Reset is
// synchronous and clears control state only. Input is held off while
// computing or while a result waits to be taken.
module shortest_path_max_delay (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [6:0]                         edge_from,
  input  logic [6:0]                         edge_to,
  input  logic [15:0]                        edge_weight,
  input  logic                               last_edge,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [22:0]                 network_delay,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [6:0]                         cfg_data
);
  localparam logic [2:0] PH_LOAD  = 3'd0;
  localparam logic [2:0] PH_SCAN  = 3'd1;
  localparam logic [2:0] PH_RELAX = 3'd2;
  localparam logic [2:0] PH_FINAL = 3'd3;
  localparam logic [2:0] PH_OUT   = 3'd4;
  localparam logic CFG_NODES  = 1'b0;
  localparam logic CFG_SOURCE = 1'b1;
  localparam int IW = spmd_pkg::IDX_W;
  localparam int DW = spmd_pkg::DIST_W;

  logic [2:0] phase;
  logic [6:0] node_count, source_node;
  logic [IW:0] n_eff;
  logic [spmd_pkg::ECNT_W-1:0] edge_total;
  logic [spmd_pkg::MAX_NODES-1:0] settled, reached;
  logic [IW:0] scan_i;           // address issue counter
  logic        scan_v;           // read data valid
  logic [IW-1:0] scan_a;         // address belonging to read data
  logic        found;
  logic [IW-1:0] best_u;
  logic [DW-1:0] best_d, cur_d;
  logic [spmd_pkg::ECNT_W-1:0] e_i;
  logic        e_v1, e_v2;       // edge read and dist read stages
  spmd_pkg::edge_t ed2;
  logic [DW-1:0] nd2;
  logic        unreach;
  logic [DW-1:0] result;

  spmd_pkg::edge_t e_rd;
  logic [DW-1:0] d_rd;
  spmd_pkg::dist_req_t dreq;
  logic accept;
  logic [IW:0] to_m1, fr_m1;

  assign accept   = in_valid && in_ready;
  assign in_ready = (phase == PH_LOAD);
  assign out_valid = (phase == PH_OUT);
  assign network_delay = result;
  assign n_eff = (node_count > 7'(spmd_pkg::MAX_NODES)) ?
                 (IW+1)'(spmd_pkg::MAX_NODES) : node_count[IW:0];

  spmd_edge_ram u_edges (
    .clk   (clk),
    .we    (accept && edge_total < (spmd_pkg::ECNT_W)'(spmd_pkg::MAX_EDGES)),
    .waddr (edge_total[spmd_pkg::EADDR_W-1:0]),
    .wdata ({edge_from, edge_to, edge_weight}),
    .raddr (e_i[spmd_pkg::EADDR_W-1:0]),
    .rdata (e_rd)
  );

  spmd_dist_ram u_dist (.clk(clk), .req(dreq), .rdata(d_rd));

  // Stage one of relaxation: edge data valid; check endpoints.
  logic e1_ok;
  assign fr_m1 = e_rd.from[IW:0] - 1'b1;
  assign e1_ok = e_v1 && e_rd.from != 7'd0 && e_rd.from <= 7'(n_eff) &&
                 fr_m1[IW-1:0] == best_u && e_rd.to != 7'd0 &&
                 e_rd.to <= 7'(n_eff);
  assign to_m1 = ed2.to[IW:0] - 1'b1;
  assign nd2   = cur_d + DW'(ed2.weight);

  // Stage two: distance of target read; relax. A write to the same node
  // the cycle before is forwarded through fwd.
  logic fwd_v;
  logic [IW-1:0] fwd_a;
  logic [DW-1:0] fwd_d, old_d;
  logic relax_wr;
  assign old_d = (fwd_v && fwd_a == to_m1[IW-1:0]) ? fwd_d : d_rd;
  assign relax_wr = e_v2 && (!reached[to_m1[IW-1:0]] || nd2 < old_d);

  always_comb begin
    dreq = '0;
    if (phase == PH_SCAN || phase == PH_FINAL) begin
      dreq.rd = 1'b1;
      dreq.raddr = scan_i[IW-1:0];
    end else if (phase == PH_RELAX) begin
      dreq.rd = 1'b1;
      dreq.raddr = e_rd.to[IW-1:0] - 1'b1;
      dreq.wr = relax_wr;
      dreq.waddr = to_m1[IW-1:0];
      dreq.wdata = nd2;
    end else if (phase == PH_LOAD && accept && last_edge) begin
      dreq.wr = 1'b1;
      dreq.waddr = IW'(source_node - 7'd1);
      dreq.wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOAD;
      node_count <= 7'd1;
      source_node <= 7'd1;
      edge_total <= '0;
      settled <= '0;
      reached <= '0;
      scan_v <= 1'b0;
      e_v1 <= 1'b0;
      e_v2 <= 1'b0;
      fwd_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODES) node_count <= cfg_data;
        else if (cfg_index == CFG_SOURCE) source_node <= cfg_data;
      end
      fwd_v <= relax_wr;
      fwd_a <= to_m1[IW-1:0];
      fwd_d <= nd2;
      case (phase)
        PH_LOAD: begin
          if (accept) begin
            if (edge_total < (spmd_pkg::ECNT_W)'(spmd_pkg::MAX_EDGES))
              edge_total <= edge_total + 1'b1;
            if (last_edge) begin
              settled <= '0;
              scan_i <= '0;
              scan_v <= 1'b0;
              found <= 1'b0;
              if (source_node == 7'd0 || source_node > 7'(n_eff)) begin
                reached <= '0;
                result <= spmd_pkg::DELAY_MASK;
                phase <= PH_OUT;
              end else begin
                reached <= (spmd_pkg::MAX_NODES)'(1) << (source_node - 7'd1);
                phase <= PH_SCAN;
              end
            end
          end
        end
        PH_SCAN: begin
          scan_v <= scan_i < n_eff;
          scan_a <= scan_i[IW-1:0];
          if (scan_i < n_eff) scan_i <= scan_i + 1'b1;
          if (scan_v && reached[scan_a] && !settled[scan_a] &&
              (!found || d_rd < best_d)) begin
            found <= 1'b1;
            best_u <= scan_a;
            best_d <= d_rd;
          end
          if (!scan_v && scan_i == n_eff) begin
            scan_i <= '0;
            if (!found) begin
              unreach <= 1'b0;
              best_d <= '0;
              phase <= PH_FINAL;
            end else begin
              settled[best_u] <= 1'b1;
              cur_d <= best_d;
              e_i <= '0;
              e_v1 <= 1'b0;
              e_v2 <= 1'b0;
              phase <= PH_RELAX;
            end
          end
        end
        PH_RELAX: begin
          e_v1 <= e_i < edge_total;
          if (e_i < edge_total) e_i <= e_i + 1'b1;
          e_v2 <= e1_ok;
          ed2 <= e_rd;
          if (relax_wr) reached[to_m1[IW-1:0]] <= 1'b1;
          if (e_i == edge_total && !e_v1 && !e_v2) begin
            scan_i <= '0;
            scan_v <= 1'b0;
            found <= 1'b0;
            phase <= PH_SCAN;
          end
        end
        PH_FINAL: begin
          scan_v <= scan_i < n_eff;
          scan_a <= scan_i[IW-1:0];
          if (scan_i < n_eff) scan_i <= scan_i + 1'b1;
          if (scan_v) begin
            if (!reached[scan_a]) unreach <= 1'b1;
            else if (d_rd > best_d) best_d <= d_rd;
          end
          if (!scan_v && scan_i == n_eff) begin
            result <= unreach ? spmd_pkg::DELAY_MASK :
                      (best_d > spmd_pkg::DELAY_MAX ? spmd_pkg::DELAY_MAX : best_d);
            phase <= PH_OUT;
          end
        end
        PH_OUT: begin
          if (out_ready) begin
            edge_total <= '0;
            phase <= PH_LOAD;
          end
        end
        default: phase <= PH_LOAD;
      endcase
    end
  end

  // A result is held only while it waits, and input is closed meanwhile.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input open while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(network_delay)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RELAX) |-> ((settled & ~reached) == '0))
    else $error("settled node not reached");
endmodule
